FILE: src/wavhdp_pkg.sv
// ----------------------------------------------------------------------------
// wavhdp_pkg
// Shared types and constants of the wav header duration parser.
// ----------------------------------------------------------------------------
package wavhdp_pkg;

    localparam int HEADER_BYTES  = 44;
    localparam int FRACTION_BITS = 16;

    // dividend is (riff_size - header) * 8 scaled by the fraction bits
    localparam int NUM_W     = 32 + 3 + FRACTION_BITS;
    localparam int DEN_W     = 64;
    localparam int DUR_W     = 51;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int OUT_W     = 152;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM  = 16'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_RIFF = 3'd1,
        ST_NOT_WAVE = 3'd2,
        ST_NOT_PCM  = 3'd3,
        ST_ZERO_DIV = 3'd4
    } status_t;

    typedef struct packed {
        logic    clear;
        logic    shift;
        logic    pos_clear;
        logic    skip_load;
        logic    skip_dec;
        logic    keep_riff;
        logic    keep_ch;
        logic    keep_rate;
        logic    keep_bits;
        logic    mul_a;
        logic    mul_b;
        logic    div_load;
        logic    div_step;
        logic    emit;
        status_t emit_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [4:0] pos;
        logic       tag_riff;
        logic       tag_wave;
        logic       tag_fmt;
        logic       tag_data;
        logic       tag_zero;
        logic       fmt_pcm;
        logic       skip_last;
        logic       den_zero;
        logic       div_last;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: src/wavhdp_ctrl.sv
// ----------------------------------------------------------------------------
// wavhdp_ctrl
// Parse sequencer: walks the riff header and chunks, then runs the duration
// multiply and divide steps in the datapath.
// ----------------------------------------------------------------------------
module wavhdp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    input  wavhdp_pkg::dp_stat_t stat,
    output wavhdp_pkg::dp_cmd_t  cmd
);

    typedef enum logic [16:0] {
        S_IDLE        = 17'b0_0000_0000_0000_0001,
        S_RIFF_ID     = 17'b0_0000_0000_0000_0010,
        S_RIFF_SIZE   = 17'b0_0000_0000_0000_0100,
        S_WAVE_ID     = 17'b0_0000_0000_0000_1000,
        S_FMT_ID      = 17'b0_0000_0000_0001_0000,
        S_FMT_SKIPSZ  = 17'b0_0000_0000_0010_0000,
        S_FMT_SKIP    = 17'b0_0000_0000_0100_0000,
        S_FMT_BODY    = 17'b0_0000_0000_1000_0000,
        S_DATA_ID     = 17'b0_0000_0001_0000_0000,
        S_DATA_SKIPSZ = 17'b0_0000_0010_0000_0000,
        S_DATA_SKIP   = 17'b0_0000_0100_0000_0000,
        S_DATA_SIZE   = 17'b0_0000_1000_0000_0000,
        S_MUL_A       = 17'b0_0001_0000_0000_0000,
        S_MUL_B       = 17'b0_0010_0000_0000_0000,
        S_CHECK       = 17'b0_0100_0000_0000_0000,
        S_DIV         = 17'b0_1000_0000_0000_0000,
        S_DONE        = 17'b1_0000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next, st_eff;
    logic   parsing;
    logic   fire;
    logic   tag_done;

    assign parsing  = !(state_reg == S_MUL_A || state_reg == S_MUL_B ||
                        state_reg == S_CHECK || state_reg == S_DIV ||
                        state_reg == S_DONE);
    assign s_tready = parsing && stat.out_free;
    assign fire     = s_tvalid && s_tready;
    assign st_eff   = s_tuser ? S_RIFF_ID : state_reg;
    assign tag_done = stat.pos >= 5'd3;

    always_comb begin
        cmd             = '0;
        cmd.emit_status = wavhdp_pkg::ST_OK;
        state_next      = state_reg;
        if (fire) begin
            cmd.clear = s_tuser;
            state_next = st_eff;
            unique case (st_eff)
                S_FMT_SKIP, S_DATA_SKIP: begin
                    cmd.skip_dec = 1'b1;
                    if (stat.skip_last) begin
                        state_next = (st_eff == S_FMT_SKIP) ? S_FMT_ID : S_DATA_ID;
                    end
                end
                S_FMT_BODY: begin
                    cmd.shift = 1'b1;
                    if (stat.pos == 5'd5) begin
                        if (!stat.fmt_pcm) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = wavhdp_pkg::ST_NOT_PCM;
                            state_next      = S_IDLE;
                        end
                    end else if (stat.pos == 5'd7) begin
                        cmd.keep_ch = 1'b1;
                    end else if (stat.pos == 5'd11) begin
                        cmd.keep_rate = 1'b1;
                    end else if (stat.pos >= 5'd19) begin
                        cmd.keep_bits = 1'b1;
                        cmd.pos_clear = 1'b1;
                        state_next    = S_DATA_ID;
                    end
                end
                S_RIFF_ID: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        if (!stat.tag_riff) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = wavhdp_pkg::ST_NOT_RIFF;
                            state_next      = S_IDLE;
                        end else begin
                            state_next = S_RIFF_SIZE;
                        end
                    end
                end
                S_RIFF_SIZE: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        cmd.keep_riff = 1'b1;
                        state_next    = S_WAVE_ID;
                    end
                end
                S_WAVE_ID: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        if (!stat.tag_wave) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = wavhdp_pkg::ST_NOT_WAVE;
                            state_next      = S_IDLE;
                        end else begin
                            state_next = S_FMT_ID;
                        end
                    end
                end
                S_FMT_ID: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        state_next    = stat.tag_fmt ? S_FMT_BODY : S_FMT_SKIPSZ;
                    end
                end
                S_FMT_SKIPSZ: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        cmd.skip_load = 1'b1;
                        state_next    = stat.tag_zero ? S_FMT_ID : S_FMT_SKIP;
                    end
                end
                S_DATA_ID: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        state_next    = stat.tag_data ? S_DATA_SIZE : S_DATA_SKIPSZ;
                    end
                end
                S_DATA_SKIPSZ: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        cmd.skip_load = 1'b1;
                        state_next    = stat.tag_zero ? S_DATA_ID : S_DATA_SKIP;
                    end
                end
                S_DATA_SIZE: begin
                    cmd.shift = 1'b1;
                    if (tag_done) begin
                        cmd.pos_clear = 1'b1;
                        state_next    = S_MUL_A;
                    end
                end
                default: begin
                    state_next = st_eff;
                end
            endcase
        end else begin
            unique case (state_reg)
                S_MUL_A: begin
                    cmd.mul_a  = 1'b1;
                    state_next = S_MUL_B;
                end
                S_MUL_B: begin
                    cmd.mul_b  = 1'b1;
                    state_next = S_CHECK;
                end
                S_CHECK: begin
                    if (stat.den_zero) begin
                        if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = wavhdp_pkg::ST_ZERO_DIV;
                            state_next      = S_IDLE;
                        end
                    end else begin
                        cmd.div_load = 1'b1;
                        state_next   = S_DIV;
                    end
                end
                S_DIV: begin
                    cmd.div_step = 1'b1;
                    if (stat.div_last) begin
                        state_next = S_DONE;
                    end
                end
                S_DONE: begin
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = wavhdp_pkg::ST_OK;
                        state_next      = S_IDLE;
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/wavhdp_dp.sv
// ----------------------------------------------------------------------------
// wavhdp_dp
// Datapath: byte shifter, position and skip counters, kept header fields,
// two-step multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module wavhdp_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [7:0]                           s_tdata,
    input  wavhdp_pkg::dp_cmd_t                  cmd,
    output wavhdp_pkg::dp_stat_t                 stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wavhdp_pkg::OUT_W-1:0]         m_tdata
);

    localparam int NUM_W = wavhdp_pkg::NUM_W;
    localparam int DEN_W = wavhdp_pkg::DEN_W;
    localparam int CNT_W = wavhdp_pkg::DIV_CNT_W;

    logic [31:0]       tag_reg, tag_base, tag_new;
    logic [4:0]        pos_reg, pos_base;
    logic [31:0]       skip_reg;
    logic [31:0]       riff_reg, rate_reg;
    logic [15:0]       ch_reg, bits_reg;
    logic [31:0]       prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [31:0]       payload;
    logic [NUM_W-1:0]  num;
    logic [DEN_W:0]    rem_sh, rem_diff;
    logic              q_bit;
    logic              m_tvalid_reg;
    logic [wavhdp_pkg::OUT_W-1:0] m_tdata_reg;

    assign tag_base = cmd.clear ? 32'd0 : tag_reg;
    assign pos_base = cmd.clear ? 5'd0 : pos_reg;
    assign tag_new  = {s_tdata, tag_base[31:8]};

    assign payload = (riff_reg >= 32'(wavhdp_pkg::HEADER_BYTES)) ?
                     riff_reg - 32'(wavhdp_pkg::HEADER_BYTES) : 32'd0;
    assign num     = NUM_W'({payload, 3'b000}) << wavhdp_pkg::FRACTION_BITS;

    assign rem_sh   = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign q_bit    = !rem_diff[DEN_W];

    always_comb begin
        stat.pos       = pos_base;
        stat.tag_riff  = tag_new == wavhdp_pkg::TAG_RIFF;
        stat.tag_wave  = tag_new == wavhdp_pkg::TAG_WAVE;
        stat.tag_fmt   = tag_new == wavhdp_pkg::TAG_FMT;
        stat.tag_data  = tag_new == wavhdp_pkg::TAG_DATA;
        stat.tag_zero  = tag_new == 32'd0;
        stat.fmt_pcm   = tag_new[31:16] == wavhdp_pkg::FMT_PCM;
        stat.skip_last = skip_reg == 32'd1;
        stat.den_zero  = den_reg == '0;
        stat.div_last  = cnt_reg == CNT_W'(NUM_W - 1);
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.pos_clear) begin
            pos_reg <= '0;
        end else if (cmd.shift) begin
            pos_reg <= pos_base + 5'd1;
        end else if (cmd.clear) begin
            pos_reg <= '0;
        end
    end

    // header fields
    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            tag_reg <= tag_new;
        end else if (cmd.clear) begin
            tag_reg <= '0;
        end
        if (cmd.skip_load) begin
            skip_reg <= tag_new;
        end else if (cmd.skip_dec) begin
            skip_reg <= skip_reg - 32'd1;
        end else if (cmd.clear) begin
            skip_reg <= '0;
        end
        if (cmd.keep_riff) begin
            riff_reg <= tag_new;
        end else if (cmd.clear) begin
            riff_reg <= '0;
        end
        if (cmd.keep_ch) begin
            ch_reg <= tag_new[31:16];
        end else if (cmd.clear) begin
            ch_reg <= '0;
        end
        if (cmd.keep_rate) begin
            rate_reg <= tag_new;
        end else if (cmd.clear) begin
            rate_reg <= '0;
        end
        if (cmd.keep_bits) begin
            bits_reg <= tag_new[31:16];
        end else if (cmd.clear) begin
            bits_reg <= '0;
        end
    end

    // divisor product and restoring divider
    always_ff @(posedge aclk) begin
        if (cmd.mul_a) begin
            prod_reg <= 32'(ch_reg) * 32'(bits_reg);
        end
        if (cmd.mul_b) begin
            den_reg <= DEN_W'(prod_reg) * DEN_W'(rate_reg);
        end
        if (cmd.div_load) begin
            rem_reg <= '0;
            quo_reg <= num;
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_load) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {2'b00,
                            (cmd.emit_status == wavhdp_pkg::ST_OK) ?
                                wavhdp_pkg::DUR_W'(quo_reg) : wavhdp_pkg::DUR_W'(0),
                            bits_reg, rate_reg, ch_reg, riff_reg,
                            cmd.emit_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/wav_header_duration_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_header_duration_parser_unit
// Parses a wav file byte stream and reports header fields and duration.
// ----------------------------------------------------------------------------
// Header bytes are taken one per cycle while s_tready is high, s_tuser
// marking the first byte of a file. An error (not riff, not wave, not pcm)
// is reported in the cycle after the offending byte. After the data chunk
// size s_tready is low while S_MUL_A, S_MUL_B form channels * bits * rate,
// S_CHECK reports a zero product as an error, a restoring divider makes
// the 51-bit q16 duration one quotient bit per cycle and S_DONE emits it.
module wav_header_duration_parser_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // start_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], riff_size[34:3], channels[50:35], sample_rate[82:51],
    // bits_per_sample[98:83], duration_q16[149:99], zero fill[151:150]
    output logic [151:0] m_tdata
);

    wavhdp_pkg::dp_cmd_t  cmd;
    wavhdp_pkg::dp_stat_t stat;

    wavhdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    wavhdp_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over a pending word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented");

    // no byte is taken while the divider runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_tready)
        else $error("input accepted during divide");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_status == wavhdp_pkg::ST_OK) |-> stat.div_last == 1'b0 &&
        $past(cmd.div_step))
        else $error("ok result without finished divide");

endmodule
